[hw/rtl/sha2bh_pkg.sv]
// sha2bh_pkg: shared types, constants and sha-256 round functions
// used by the schedule, round and top-level modules of the byte hasher
// no dependencies
package sha2bh_pkg;

  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned HASH_WORDS = 8;

  localparam logic       REQ_APPEND = 1'b0;
  localparam logic       REQ_FINISH = 1'b1;
  localparam logic       MODE_256   = 1'b0;
  localparam logic       MODE_224   = 1'b1;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_256 [0:HASH_WORDS-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] IV_224 [0:HASH_WORDS-1] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        length_error;
  } out_item_t;

  // control from the sequencer to the block window
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       shift_word;
  } sched_ctrl_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       load_iv;
    logic       iv_224;
    logic       load_work;
    logic       do_round;
    logic       add_hash;
    logic [5:0] rnd;
  } rnd_ctrl_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

[hw/rtl/sha2bh_sched.sv]
// sha2bh_sched: 512-bit block window, filled a byte at a time and then
// stepped a word per round as the sha-256 message schedule
// depends on sha2bh_pkg
module sha2bh_sched (
  input  logic                     clk,
  input  sha2bh_pkg::sched_ctrl_t  ctrl,
  output logic [31:0]              w_t
);
  import sha2bh_pkg::*;

  // word 0 (oldest) sits in the top bits
  logic [511:0] win_r;
  logic [31:0]  w0, w1, w9, w14;
  logic [31:0]  w_new;

  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];

  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
  assign w_t   = w0;

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      win_r <= {win_r[503:0], ctrl.byte_val};
    end else if (ctrl.shift_word) begin
      win_r <= {win_r[479:0], w_new};
    end
  end

endmodule

[hw/rtl/sha2bh_round.sv]
// sha2bh_round: chained hash words and the a..h working registers,
// one compression round per cycle plus the final feed-forward add
// depends on sha2bh_pkg
module sha2bh_round (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha2bh_pkg::rnd_ctrl_t  ctrl,
  input  logic [31:0]            w_t,
  input  logic [2:0]             rd_idx,
  output logic [31:0]            rd_word
);
  import sha2bh_pkg::*;

  logic [31:0] hash_r [0:HASH_WORDS-1];
  logic [31:0] work_r [0:HASH_WORDS-1];
  logic [31:0] t1, t2;

  assign t1 = work_r[7] + big_sigma1(work_r[4]) + choose(work_r[4], work_r[5], work_r[6])
            + ROUND_K[ctrl.rnd] + w_t;
  assign t2 = big_sigma0(work_r[0]) + majority(work_r[0], work_r[1], work_r[2]);

  assign rd_word = hash_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HASH_WORDS; i++) hash_r[i] <= IV_256[i];
    end else if (ctrl.load_iv) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash_r[i] <= ctrl.iv_224 ? IV_224[i] : IV_256[i];
      end
    end else if (ctrl.add_hash) begin
      for (int i = 0; i < HASH_WORDS; i++) hash_r[i] <= hash_r[i] + work_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_work) begin
      for (int i = 0; i < HASH_WORDS; i++) work_r[i] <= hash_r[i];
    end else if (ctrl.do_round) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
    end
  end

endmodule

[hw/rtl/sha224_256_byte_hasher_core.sv]
// sha224_256_byte_hasher_core: byte-serial sha-224 / sha-256 hasher top level
// depends on sha2bh_pkg, sha2bh_sched and sha2bh_round
//
// Message bytes enter one item at a time (req_type 0) and are shifted into a
// 512-bit block window; in_stall stays low after an append item, except the
// one that completes a 64-byte block: that one holds in_stall while the
// working registers are loaded, the 64 rounds run at one per cycle on the
// single round datapath and the feed-forward add is done. A finish item
// (req_type 1) shifts in the 0x80 mark, zero bytes and the 8 length bytes
// one per cycle, compressing once or twice, then emits 8 digest words
// (sha-256) or 7 (sha-224), one per cycle while out_stall is low; words are
// big-endian, index 0 first, last set on the final one. Afterwards the hash
// restarts from the initial value of the current mode. An append that would
// push the bit length to 2^64 yields one item with length_error and last set
// and leaves the message untouched. Writing cfg_wr_data (0 = sha-256,
// 1 = sha-224) with cfg_wr_en restarts the message; write only while idle.
module sha224_256_byte_hasher_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sha2bh_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sha2bh_pkg::out_item_t  out_item
);
  import sha2bh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  // sequencer state
  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;        // bytes in the current block
  logic [60:0] cnt_r, cnt_nxt;          // message length in bytes
  logic        mode_r, mode_nxt;
  logic        fin_r, fin_nxt;          // finish in progress
  logic        sent80_r, sent80_nxt;
  logic        len_phase_r, len_phase_nxt;
  logic        len_done_r, len_done_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  emit_idx_r, emit_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  sched_ctrl_t sctl;
  rnd_ctrl_t   rctl;
  logic [31:0] w_t;
  logic [31:0] hash_word;
  logic        in_fire, out_fire, out_free;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic        emit_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // big-endian length field, most significant byte first
  assign bit_len   = {cnt_r, 3'b000};
  assign len_byte  = bit_len[{~len_idx_r, 3'b000} +: 8];
  assign emit_last = (emit_idx_r == ((mode_r == MODE_224) ? 3'd6 : 3'd7));

  sha2bh_sched u_sched (
    .clk  (clk),
    .ctrl (sctl),
    .w_t  (w_t)
  );

  sha2bh_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rctl),
    .w_t     (w_t),
    .rd_idx  (emit_idx_r),
    .rd_word (hash_word)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    fin_nxt       = fin_r;
    sent80_nxt    = sent80_r;
    len_phase_nxt = len_phase_r;
    len_done_nxt  = len_done_r;
    len_idx_nxt   = len_idx_r;
    rnd_nxt       = rnd_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_nxt       = out_r;
    sctl          = '0;
    rctl          = '0;
    rctl.rnd      = rnd_r;
    rctl.iv_224   = mode_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.req_type == REQ_FINISH) begin
            fin_nxt       = 1'b1;
            sent80_nxt    = 1'b0;
            len_phase_nxt = 1'b0;
            len_done_nxt  = 1'b0;
            len_idx_nxt   = 3'd0;
            state_nxt     = S_PAD;
          end else if (&cnt_r) begin
            // length would reach 2^64 bits: reject the byte
            state_nxt = S_ERR;
          end else begin
            sctl.shift_byte = 1'b1;
            sctl.byte_val   = in_item.data_byte;
            cnt_nxt         = cnt_r + 61'd1;
            fill_nxt        = fill_r + 6'd1;
            if (&fill_r) state_nxt = S_LOAD;
          end
        end
      end
      S_PAD: begin
        sctl.shift_byte = 1'b1;
        fill_nxt        = fill_r + 6'd1;
        if (!sent80_r) begin
          sctl.byte_val = PAD_MARK;
          sent80_nxt    = 1'b1;
        end else if (!len_phase_r && (fill_r != 6'd56)) begin
          sctl.byte_val = 8'h00;
        end else begin
          sctl.byte_val = len_byte;
          len_phase_nxt = 1'b1;
          len_idx_nxt   = len_idx_r + 3'd1;
          if (&len_idx_r) len_done_nxt = 1'b1;
        end
        if (&fill_r) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        rctl.load_work = 1'b1;
        rnd_nxt        = 6'd0;
        state_nxt      = S_ROUND;
      end
      S_ROUND: begin
        rctl.do_round   = 1'b1;
        sctl.shift_word = 1'b1;
        rnd_nxt         = rnd_r + 6'd1;
        if (&rnd_r) state_nxt = S_ADD;
      end
      S_ADD: begin
        rctl.add_hash = 1'b1;
        if (len_done_r) begin
          emit_idx_nxt = 3'd0;
          state_nxt    = S_EMIT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_nxt.digest_word      = hash_word;
          out_nxt.word_index       = emit_idx_r;
          out_nxt.last             = emit_last;
          out_nxt.length_error     = 1'b0;
          emit_idx_nxt             = emit_idx_r + 3'd1;
          if (emit_last) begin
            // restart from the mode's initial value
            rctl.load_iv  = 1'b1;
            fill_nxt      = 6'd0;
            cnt_nxt       = '0;
            fin_nxt       = 1'b0;
            sent80_nxt    = 1'b0;
            len_phase_nxt = 1'b0;
            len_done_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.digest_word  = '0;
          out_nxt.word_index   = '0;
          out_nxt.last         = 1'b1;
          out_nxt.length_error = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // mode write restarts the message
    if (cfg_wr_en) begin
      mode_nxt     = cfg_wr_data;
      rctl.load_iv = 1'b1;
      rctl.iv_224  = cfg_wr_data;
      fill_nxt     = 6'd0;
      cnt_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= 6'd0;
      cnt_r       <= '0;
      mode_r      <= MODE_256;
      fin_r       <= 1'b0;
      sent80_r    <= 1'b0;
      len_phase_r <= 1'b0;
      len_done_r  <= 1'b0;
      len_idx_r   <= 3'd0;
      rnd_r       <= 6'd0;
      emit_idx_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      fin_r       <= fin_nxt;
      sent80_r    <= sent80_nxt;
      len_phase_r <= len_phase_nxt;
      len_done_r  <= len_done_nxt;
      len_idx_r   <= len_idx_nxt;
      rnd_r       <= rnd_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // an error item always carries last and a zero word
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.length_error |-> out_r.last && (out_r.digest_word == 32'd0))
    else $error("error item without last or with nonzero word");

  // a pending non-final digest word means the sequencer is still emitting
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> (state_r == S_EMIT))
    else $error("non-final digest word pending outside emit");

  // the last round is always followed by the feed-forward add
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) && (&rnd_r) |=> (state_r == S_ADD))
    else $error("round 63 not followed by hash add");

  // no new item is taken while padding or while a block is being compressed
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) || (state_r == S_PAD) |-> in_stall)
    else $error("input accepted during padding or compression");

endmodule
